[hw/rtl/md5_pkg.sv]
// md5_pkg: shared types, constants and microcode ROM of the MD5 hasher.
// Used by md5_message_digest; depends on nothing else.
`timescale 1ns / 1ps

package md5_pkg;

  // Chaining value after reset and after every digest
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] PAD_WORD = 32'h0000_0080;

  // Step codes of the sequencer program
  localparam logic [2:0] STEP_IN    = 3'd0;  // take a message word
  localparam logic [2:0] STEP_PAD   = 3'd1;  // push pad, zero or length word
  localparam logic [2:0] STEP_ROUND = 3'd2;  // one compression round
  localparam logic [2:0] STEP_FINAL = 3'd3;  // add round words into the chain
  localparam logic [2:0] STEP_EMIT  = 3'd4;  // hand out the digest

  typedef enum logic [1:0] {
    JMP_PUSH,   // wrapped block -> target, else IN or PAD
    JMP_LOOP,   // stay until the last round, then target
    JMP_FIN,    // digest done -> target, else IN or PAD
    JMP_EMIT    // wait for the output register, then target
  } jmp_e;

  typedef struct packed {
    logic       take_in;
    logic       push_pad;
    logic       do_round;
    logic       do_final;
    logic       do_emit;
    jmp_e       jmp;
    logic [2:0] target;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [2:0] step);
    ctrl_t c;
    c = '{take_in: 1'b0, push_pad: 1'b0, do_round: 1'b0, do_final: 1'b0,
          do_emit: 1'b0, jmp: JMP_EMIT, target: STEP_IN};
    case (step)
      STEP_IN: begin
        c.take_in = 1'b1;
        c.jmp     = JMP_PUSH;
        c.target  = STEP_ROUND;
      end
      STEP_PAD: begin
        c.push_pad = 1'b1;
        c.jmp      = JMP_PUSH;
        c.target   = STEP_ROUND;
      end
      STEP_ROUND: begin
        c.do_round = 1'b1;
        c.jmp      = JMP_LOOP;
        c.target   = STEP_FINAL;
      end
      STEP_FINAL: begin
        c.do_final = 1'b1;
        c.jmp      = JMP_FIN;
        c.target   = STEP_EMIT;
      end
      STEP_EMIT: begin
        c.do_emit = 1'b1;
        c.jmp     = JMP_EMIT;
        c.target  = STEP_IN;
      end
      default: begin
        c.jmp    = JMP_EMIT;
        c.target = STEP_IN;
      end
    endcase
    return c;
  endfunction

  // Left rotate amount per round group and round position
  function automatic logic [4:0] rot_amt(input logic [1:0] grp, input logic [1:0] pos);
    logic [4:0] r;
    case ({grp, pos})
      4'h0: r = 5'd7;   4'h1: r = 5'd12;  4'h2: r = 5'd17;  4'h3: r = 5'd22;
      4'h4: r = 5'd5;   4'h5: r = 5'd9;   4'h6: r = 5'd14;  4'h7: r = 5'd20;
      4'h8: r = 5'd4;   4'h9: r = 5'd11;  4'ha: r = 5'd16;  4'hb: r = 5'd23;
      4'hc: r = 5'd6;   4'hd: r = 5'd10;  4'he: r = 5'd15;  default: r = 5'd21;
    endcase
    return r;
  endfunction

  // Additive round constants
  function automatic logic [31:0] sine_k(input logic [5:0] j);
    logic [31:0] k;
    case (j)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage

[hw/rtl/md5_message_digest.sv]
// md5_message_digest: streaming MD5 hasher run by a microcoded sequencer.
// Depends on md5_pkg (microcode ROM, round constants, chaining values).
`timescale 1ns / 1ps
//
//  channel   dir  payload                               request marker
//  s_axis    in   data_word[31:0], byte_count[34:32]     tlast = last word
//  m_axis    out  digest_a..digest_d (a in bits 31:0)    one per message
//
//  Every 16 message words the shared round unit runs 64 rounds plus one chain
//  update; no new words are taken while it runs.
//  The last word adds 1..2 pad blocks of push steps and rounds, then one emit.
//  Reset loads the standard chaining value and waits for the first request.
//  A stalled digest holds in the output register; new words are still taken
//  until the next digest is ready to be emitted.

module md5_message_digest
  import md5_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [39:0]  s_axis_tdata_i,   // data_word[31:0], byte_count[34:32], zero
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o    // digest_a, digest_b, digest_c, digest_d
);

  logic [2:0]   step_q, step_d;
  logic [5:0]   round_q, round_d;
  logic [3:0]   words_q, words_d;
  logic [60:0]  msg_q, msg_d;
  logic         fin_q, fin_d;
  logic         pend80_q, pend80_d;
  logic         lo_done_q, lo_done_d;
  logic         done_q, done_d;
  logic         out_valid_q, out_valid_d;
  logic [31:0]  chain_q [4];
  logic [31:0]  chain_d [4];
  logic [31:0]  rw_q [4];
  logic [31:0]  rw_d [4];
  logic [31:0]  buf_q [16];
  logic [127:0] out_q, out_d;

  ctrl_t        ctrl;
  logic         accept;
  logic         push;
  logic         wrap;
  logic [31:0]  push_val;
  logic [31:0]  in_word;
  logic [2:0]   in_cnt;
  logic [31:0]  in_val;
  logic [31:0]  len_lo;
  logic [31:0]  len_hi;
  logic [1:0]   grp;
  logic [3:0]   jl;
  logic [3:0]   idx;
  logic [31:0]  fn;
  logic [31:0]  sum;
  logic [63:0]  rot_wide;
  logic         out_free;

  assign ctrl     = ucode(step_q);
  assign in_word  = s_axis_tdata_i[31:0];
  assign in_cnt   = (s_axis_tdata_i[34:32] > 3'd4) ? 3'd4 : s_axis_tdata_i[34:32];
  assign accept   = ctrl.take_in && s_axis_tvalid_i;
  assign push     = accept || ctrl.push_pad;
  assign wrap     = push && (words_q == 4'd15);
  assign len_lo   = {msg_q[28:0], 3'b000};
  assign len_hi   = msg_q[60:29];
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Final word: drop bytes above the count and drop the pad byte in behind them
  always_comb begin
    in_val = in_word;
    if (s_axis_tlast_i) begin
      case (in_cnt)
        3'd0:    in_val = PAD_WORD;
        3'd1:    in_val = {16'h0000, 8'h80, in_word[7:0]};
        3'd2:    in_val = {8'h00, 8'h80, in_word[15:0]};
        3'd3:    in_val = {8'h80, in_word[23:0]};
        default: in_val = in_word;
      endcase
    end
  end

  // Round function of the shared round unit
  always_comb begin
    grp = round_q[5:4];
    jl  = round_q[3:0];
    case (grp)
      2'd0: begin
        fn  = (rw_q[1] & rw_q[2]) | (~rw_q[1] & rw_q[3]);
        idx = jl;
      end
      2'd1: begin
        fn  = (rw_q[3] & rw_q[1]) | (~rw_q[3] & rw_q[2]);
        idx = jl * 4'd5 + 4'd1;
      end
      2'd2: begin
        fn  = rw_q[1] ^ rw_q[2] ^ rw_q[3];
        idx = jl * 4'd3 + 4'd5;
      end
      default: begin
        fn  = rw_q[2] ^ (rw_q[1] | ~rw_q[3]);
        idx = jl * 4'd7;
      end
    endcase
    sum      = rw_q[0] + fn + sine_k(round_q) + buf_q[idx];
    rot_wide = {32'h0, sum} << rot_amt(grp, round_q[1:0]);
  end

  always_comb begin
    step_d      = step_q;
    round_d     = round_q;
    words_d     = words_q;
    msg_d       = msg_q;
    fin_d       = fin_q;
    pend80_d    = pend80_q;
    lo_done_d   = lo_done_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_d       = out_q;
    chain_d     = chain_q;
    rw_d        = rw_q;
    push_val    = in_val;

    if (accept) begin
      fin_d    = s_axis_tlast_i;
      pend80_d = s_axis_tlast_i && (in_cnt == 3'd4);
      msg_d    = msg_q + (s_axis_tlast_i ? 61'(in_cnt) : 61'd4);
    end

    // Pad order: trailing pad byte, zero fill, length low word, length high word
    if (ctrl.push_pad) begin
      if (pend80_q) begin
        push_val = PAD_WORD;
        pend80_d = 1'b0;
      end else if (lo_done_q) begin
        push_val = len_hi;
        done_d   = 1'b1;
      end else if (words_q == 4'd14) begin
        push_val  = len_lo;
        lo_done_d = 1'b1;
      end else begin
        push_val = 32'h0;
      end
    end

    if (push) begin
      words_d = words_q + 4'd1;
    end
    // Load the working words from the chaining value as the block completes
    if (wrap) begin
      rw_d = chain_q;
    end

    if (ctrl.do_round) begin
      rw_d[0] = rw_q[3];
      rw_d[3] = rw_q[2];
      rw_d[2] = rw_q[1];
      rw_d[1] = rw_q[1] + (rot_wide[31:0] | rot_wide[63:32]);
      round_d = round_q + 6'd1;
    end

    if (ctrl.do_final) begin
      for (int i = 0; i < 4; i++) begin
        chain_d[i] = chain_q[i] + rw_q[i];
      end
    end

    if (ctrl.do_emit && out_free) begin
      out_d       = {chain_q[3], chain_q[2], chain_q[1], chain_q[0]};
      out_valid_d = 1'b1;
      chain_d[0]  = IV_A;
      chain_d[1]  = IV_B;
      chain_d[2]  = IV_C;
      chain_d[3]  = IV_D;
      msg_d       = '0;
      fin_d       = 1'b0;
      pend80_d    = 1'b0;
      lo_done_d   = 1'b0;
      done_d      = 1'b0;
    end

    // Sequencer: next step from the control word's jump field
    case (ctrl.jmp)
      JMP_PUSH: begin
        if (push) begin
          if (wrap) begin
            step_d = ctrl.target;
          end else if (fin_d) begin
            step_d = STEP_PAD;
          end else begin
            step_d = STEP_IN;
          end
        end
      end
      JMP_LOOP: begin
        if (round_q == 6'd63) begin
          step_d = ctrl.target;
        end
      end
      JMP_FIN: begin
        if (done_q) begin
          step_d = ctrl.target;
        end else if (fin_q) begin
          step_d = STEP_PAD;
        end else begin
          step_d = STEP_IN;
        end
      end
      default: begin
        if (out_free) begin
          step_d = ctrl.target;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IN;
      round_q     <= '0;
      words_q     <= '0;
      msg_q       <= '0;
      fin_q       <= 1'b0;
      pend80_q    <= 1'b0;
      lo_done_q   <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      chain_q[0]  <= IV_A;
      chain_q[1]  <= IV_B;
      chain_q[2]  <= IV_C;
      chain_q[3]  <= IV_D;
    end else begin
      step_q      <= step_d;
      round_q     <= round_d;
      words_q     <= words_d;
      msg_q       <= msg_d;
      fin_q       <= fin_d;
      pend80_q    <= pend80_d;
      lo_done_q   <= lo_done_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
      chain_q     <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rw_q  <= rw_d;
    out_q <= out_d;
    if (push) begin
      buf_q[words_q] <= push_val;
    end
  end

  assign s_axis_tready_o = ctrl.take_in;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule
